FILE: sv/piecewise_linear_sensor_calibration_core_macros.svh
// assertion macros used by the port-level checker file
`ifndef PIECEWISE_LINEAR_SENSOR_CALIBRATION_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_SENSOR_CALIBRATION_CORE_MACROS_SVH

// same-cycle implication
`define PLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/plc_pkg.sv
// shared types and constants of the sensor calibration core
`default_nettype none

package plc_pkg;

  localparam int MV_W       = 13;
  localparam int RD_W       = 16;
  localparam int OP_W       = 2;
  localparam int HELD_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PT_W       = MV_W + RD_W;

  localparam int DEF_MAX_POINTS = 16;

  localparam int DIVIDEND_W = MV_W + RD_W;
  localparam int DIVISOR_W  = MV_W;

  localparam logic [OP_W-1:0] OP_CONVERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_READING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLED  = 3'd3;

  localparam logic [MV_W-1:0] RST_EMPTY_MV     = 13'd500;
  localparam logic [MV_W-1:0] RST_FULL_MV      = 13'd3000;
  localparam logic [RD_W-1:0] RST_FULL_READING = 16'd10000;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic [RD_W-1:0] rd;
  } point_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/plc_ifs.sv
// valid/ready channel interfaces of the sensor calibration core
`default_nettype none

interface plc_in_if import plc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [MV_W-1:0] volts_mv;
  logic [RD_W-1:0] point_reading;

  modport source (output valid, output operation, output volts_mv, output point_reading,
                  input ready);
  modport sink   (input valid, input operation, input volts_mv, input point_reading,
                  output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RD_W-1:0]   reading;
  logic              is_raw;
  logic [HELD_W-1:0] points_held;
  logic              point_dropped;

  modport source (output valid, output reading, output is_raw, output points_held,
                  output point_dropped, input ready);
  modport sink   (input valid, input reading, input is_raw, input points_held,
                  input point_dropped, output ready);
endinterface

interface plc_cfg_if import plc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/plc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/plc_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module plc_div import plc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int SW = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;

  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    ge     = rem_sh >= {1'b0, dsr_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(DIVIDEND_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

FILE: sv/piecewise_linear_sensor_calibration_core.sv
// top level of the piecewise-linear sensor calibration core
// raw pass-through, clear, dropped insert, unused codes: idle goes straight to finish
// insert: compare state shifts larger entries up and writes the point, put state writes
// slot 0; empty table written from idle; table convert: last point check, segment walk
// through the point ram, multiply, 29-step serial divider; legacy convert: multiply, divide
// one item at a time; input ready in the same cycle the result is in the output register
// synchronous active-low reset clears point count, sequencer, out valid; config to defaults
`default_nettype none

module piecewise_linear_sensor_calibration_core import plc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  plc_in_if.sink     in_if,
  plc_out_if.source  out_if,
  plc_cfg_if.sink    cfg_if
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INS_CMP  = 8'b0000_0010,
    ST_INS_PUT  = 8'b0000_0100,
    ST_CNV_LAST = 8'b0000_1000,
    ST_CNV_WALK = 8'b0001_0000,
    ST_MUL      = 8'b0010_0000,
    ST_DIV      = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [MV_W-1:0]   v_r, v_nxt;
  logic [RD_W-1:0]   prd_r, prd_nxt;
  logic              legacy_r, legacy_nxt;
  logic              neg_r, neg_nxt;
  point_t            prev_r, prev_nxt;
  point_t            cur_r, cur_nxt;
  logic [RD_W-1:0]   res_rd_r, res_rd_nxt;
  logic              res_raw_r, res_raw_nxt;
  logic              res_drop_r, res_drop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RD_W-1:0]   out_reading_r, out_reading_nxt;
  logic              out_raw_r, out_raw_nxt;
  logic [HELD_W-1:0] out_held_r, out_held_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic [MV_W-1:0]   empty_mv_r, empty_mv_nxt;
  logic [MV_W-1:0]   full_mv_r, full_mv_nxt;
  logic [RD_W-1:0]   full_rd_r, full_rd_nxt;
  logic              cal_en_r, cal_en_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  point_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [PT_W-1:0] ram_rdata;
  point_t          rd_pt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  in_xfer;
  logic                  out_take;
  logic                  out_load;
  logic [MV_W:0]         d_leg;
  logic [MV_W:0]         span_leg;
  logic [MV_W-1:0]       dmag;
  logic [MV_W-1:0]       smag;
  logic [RD_W:0]         dr;
  logic [RD_W-1:0]       drmag;
  logic [MV_W-1:0]       mul_a;
  logic [RD_W-1:0]       mul_b;
  logic [DIVIDEND_W-1:0] product;

  plc_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_plc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plc_div u_plc_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign out_take     = out_valid_r && out_if.ready;
  assign out_load     = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);
  assign rd_pt        = point_t'(ram_rdata);

  // operand select for the one multiplier
  always_comb begin
    d_leg    = {1'b0, v_r} - {1'b0, empty_mv_r};
    span_leg = {1'b0, full_mv_r} - {1'b0, empty_mv_r};
    dmag     = d_leg[MV_W] ? MV_W'(-d_leg) : d_leg[MV_W-1:0];
    smag     = span_leg[MV_W] ? MV_W'(-span_leg) : span_leg[MV_W-1:0];
    dr       = {1'b0, cur_r.rd} - {1'b0, prev_r.rd};
    drmag    = dr[RD_W] ? RD_W'(-dr) : dr[RD_W-1:0];
    if (legacy_r) begin
      mul_a = dmag;
      mul_b = full_rd_r;
    end else begin
      mul_a = v_r - prev_r.mv;
      mul_b = drmag;
    end
    product = DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b);
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    v_nxt        = v_r;
    prd_nxt      = prd_r;
    legacy_nxt   = legacy_r;
    neg_nxt      = neg_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    res_rd_nxt   = res_rd_r;
    res_raw_nxt  = res_raw_r;
    res_drop_nxt = res_drop_r;
    empty_mv_nxt = empty_mv_r;
    full_mv_nxt  = full_mv_r;
    full_rd_nxt  = full_rd_r;
    cal_en_nxt   = cal_en_r;

    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = '{mv: v_r, rd: prd_r};
    ram_raddr = '0;

    div_req.start    = 1'b0;
    div_req.dividend = product;
    div_req.divisor  = legacy_r ? smag : (cur_r.mv - prev_r.mv);

    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_EMPTY_MV:     empty_mv_nxt = cfg_if.data[MV_W-1:0];
        CFG_FULL_MV:      full_mv_nxt  = cfg_if.data[MV_W-1:0];
        CFG_FULL_READING: full_rd_nxt  = cfg_if.data[RD_W-1:0];
        CFG_CAL_ENABLED:  cal_en_nxt   = cfg_if.data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          v_nxt        = in_if.volts_mv;
          prd_nxt      = in_if.point_reading;
          res_rd_nxt   = '0;
          res_raw_nxt  = 1'b0;
          res_drop_nxt = 1'b0;
          state_nxt    = ST_FINISH;
          case (in_if.operation)
            OP_CONVERT: begin
              if (!cal_en_r) begin
                res_rd_nxt  = RD_W'(in_if.volts_mv);
                res_raw_nxt = 1'b1;
              end else if (cnt_r >= CW'(2)) begin
                legacy_nxt = 1'b0;
                ram_raddr  = AW'(cnt_r - CW'(1));
                state_nxt  = ST_CNV_LAST;
              end else if (full_mv_r != empty_mv_r) begin
                legacy_nxt = 1'b1;
                state_nxt  = ST_MUL;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_INSERT: begin
              if (cnt_r >= CW'(MAX_POINTS)) begin
                res_drop_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{mv: in_if.volts_mv, rd: in_if.point_reading};
                cnt_nxt   = CW'(1);
              end else begin
                pos_nxt   = AW'(cnt_r);
                ram_raddr = AW'(cnt_r - CW'(1));
                state_nxt = ST_INS_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_pt.mv > v_r) begin
          ram_wdata = rd_pt;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = ST_INS_PUT;
          end else begin
            ram_raddr = pos_r - AW'(2);
          end
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_FINISH;
        end
      end

      ST_INS_PUT: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = ST_FINISH;
      end

      ST_CNV_LAST: begin
        if (v_r > rd_pt.mv) begin
          res_rd_nxt = rd_pt.rd;
          state_nxt  = ST_FINISH;
        end else begin
          // keep the last point, the first point wins when both ends match
          cur_nxt   = rd_pt;
          pos_nxt   = '0;
          ram_raddr = '0;
          state_nxt = ST_CNV_WALK;
        end
      end

      ST_CNV_WALK: begin
        if (v_r <= rd_pt.mv) begin
          if (pos_r == '0) begin
            res_rd_nxt = rd_pt.rd;
            state_nxt  = ST_FINISH;
          end else if (rd_pt.mv == prev_r.mv) begin
            res_rd_nxt = prev_r.rd;
            state_nxt  = ST_FINISH;
          end else begin
            cur_nxt   = rd_pt;
            state_nxt = ST_MUL;
          end
        end else if (pos_r == '0 && v_r >= cur_r.mv) begin
          res_rd_nxt = cur_r.rd;
          state_nxt  = ST_FINISH;
        end else begin
          prev_nxt  = rd_pt;
          pos_nxt   = pos_r + AW'(1);
          ram_raddr = pos_r + AW'(1);
        end
      end

      ST_MUL: begin
        div_req.start = 1'b1;
        neg_nxt       = legacy_r ? (d_leg[MV_W] ^ span_leg[MV_W]) : dr[RD_W];
        state_nxt     = ST_DIV;
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (legacy_r) begin
            if (neg_r) begin
              res_rd_nxt = '0;
            end else if (div_rsp.quotient > DIVIDEND_W'(full_rd_r)) begin
              res_rd_nxt = full_rd_r;
            end else begin
              res_rd_nxt = div_rsp.quotient[RD_W-1:0];
            end
          end else if (neg_r) begin
            res_rd_nxt = prev_r.rd - div_rsp.quotient[RD_W-1:0];
          end else begin
            res_rd_nxt = prev_r.rd + div_rsp.quotient[RD_W-1:0];
          end
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_reading_nxt = out_reading_r;
    out_raw_nxt     = out_raw_r;
    out_held_nxt    = out_held_r;
    out_drop_nxt    = out_drop_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_reading_nxt = res_rd_r;
      out_raw_nxt     = res_raw_r;
      out_held_nxt    = HELD_W'(cnt_r);
      out_drop_nxt    = res_drop_r;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      empty_mv_r  <= RST_EMPTY_MV;
      full_mv_r   <= RST_FULL_MV;
      full_rd_r   <= RST_FULL_READING;
      cal_en_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      empty_mv_r  <= empty_mv_nxt;
      full_mv_r   <= full_mv_nxt;
      full_rd_r   <= full_rd_nxt;
      cal_en_r    <= cal_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    v_r           <= v_nxt;
    prd_r         <= prd_nxt;
    legacy_r      <= legacy_nxt;
    neg_r         <= neg_nxt;
    prev_r        <= prev_nxt;
    cur_r         <= cur_nxt;
    res_rd_r      <= res_rd_nxt;
    res_raw_r     <= res_raw_nxt;
    res_drop_r    <= res_drop_nxt;
    out_reading_r <= out_reading_nxt;
    out_raw_r     <= out_raw_nxt;
    out_held_r    <= out_held_nxt;
    out_drop_r    <= out_drop_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.reading       = out_reading_r;
  assign out_if.is_raw        = out_raw_r;
  assign out_if.points_held   = out_held_r;
  assign out_if.point_dropped = out_drop_r;

endmodule

`default_nettype wire

FILE: sv/plc_checker.sv
// port-level assertions of the calibration core and their bind
`default_nettype none
`include "piecewise_linear_sensor_calibration_core_macros.svh"

module plc_checker import plc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [RD_W-1:0]   out_reading,
  input wire logic              out_is_raw,
  input wire logic [HELD_W-1:0] out_points_held,
  input wire logic              out_point_dropped
);

  // busy in the cycle after each input transfer
  `PLC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "ready after transfer")

  // stalled result holds
  `PLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_reading) && $stable(out_points_held), "stalled result changed")

  // raw pass-through stays within millivolt range and never flags a drop
  `PLC_ASSERT_NOW(a_raw_range, clk, rst_n, out_valid && out_is_raw, !out_point_dropped && ((out_reading >> MV_W) == '0), "bad raw result")

  // a dropped insert only happens with a full table
  `PLC_ASSERT_NOW(a_drop_full, clk, rst_n, out_valid && out_point_dropped, !out_is_raw && (out_reading == '0) && (out_points_held == HELD_W'(MAX_POINTS)), "drop without full table")

endmodule

bind piecewise_linear_sensor_calibration_core plc_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_plc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_reading       (out_if.reading),
  .out_is_raw        (out_if.is_raw),
  .out_points_held   (out_if.points_held),
  .out_point_dropped (out_if.point_dropped)
);

`default_nettype wire

FILE: test/plc_reading_checker.sv
// checker: predicts the calibration core's readings and compares each result transfer
module plc_reading_checker
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  plc_in_if         in_ch,
  plc_out_if        out_ch,
  plc_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RD_W-1:0]   reading;
    logic              is_raw;
    logic [HELD_W-1:0] points_held;
    logic              point_dropped;
  } reading_t;

  reading_t        expected_readings[$];
  point_t          cal_points[MAX_POINTS];
  int unsigned     n_points;
  logic [MV_W-1:0] empty_mv;
  logic [MV_W-1:0] full_mv;
  logic [RD_W-1:0] full_reading;
  logic            cal_enabled;

  always @(posedge clk) begin : track
    reading_t        want;
    reading_t        got;
    longint          span;
    longint          level;
    longint          dv;
    longint          dr;
    int unsigned     pos;
    int              i;
    logic            hit;
    logic [MV_W-1:0] v;
    if (!rst_n) begin
      expected_readings.delete();
      n_points     = 0;
      empty_mv     = RST_EMPTY_MV;
      full_mv      = RST_FULL_MV;
      full_reading = RST_FULL_READING;
      cal_enabled  = 1'b0;
      fail_count   = 0;
      pending_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_EMPTY_MV:     empty_mv     = cfg_ch.data[MV_W-1:0];
          CFG_FULL_MV:      full_mv      = cfg_ch.data[MV_W-1:0];
          CFG_FULL_READING: full_reading = cfg_ch.data[RD_W-1:0];
          CFG_CAL_ENABLED:  cal_enabled  = cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        want = '0;
        v = in_ch.volts_mv;
        case (in_ch.operation)
          OP_CONVERT: begin
            if (!cal_enabled) begin
              want.reading = RD_W'(v);
              want.is_raw  = 1'b1;
            end else if (n_points >= 2) begin
              if (v <= cal_points[0].mv) begin
                want.reading = cal_points[0].rd;
              end else if (v >= cal_points[n_points-1].mv) begin
                want.reading = cal_points[n_points-1].rd;
              end else begin
                hit = 1'b0;
                want.reading = cal_points[n_points-1].rd;
                for (i = 0; i + 1 < n_points && !hit; i++) begin
                  if (v >= cal_points[i].mv && v <= cal_points[i+1].mv) begin
                    hit = 1'b1;
                    dv = longint'(cal_points[i+1].mv) - longint'(cal_points[i].mv);
                    dr = longint'(cal_points[i+1].rd) - longint'(cal_points[i].rd);
                    if (dv <= 0) begin
                      want.reading = cal_points[i].rd;
                    end else begin
                      level = (longint'(v) - longint'(cal_points[i].mv)) * dr / dv;
                      want.reading = RD_W'(longint'(cal_points[i].rd) + level);
                    end
                  end
                end
              end
            end else begin
              span = longint'(full_mv) - longint'(empty_mv);
              if (span != 0) begin
                level = (longint'(v) - longint'(empty_mv)) * longint'(full_reading) / span;
                if (level < 0) level = 0;
                if (level > longint'(full_reading)) level = longint'(full_reading);
                want.reading = RD_W'(level);
              end
            end
          end
          OP_CLEAR: n_points = 0;
          OP_INSERT: begin
            if (n_points >= MAX_POINTS) begin
              want.point_dropped = 1'b1;
            end else begin
              pos = n_points;
              while (pos > 0 && cal_points[pos-1].mv > v) begin
                cal_points[pos] = cal_points[pos-1];
                pos--;
              end
              cal_points[pos] = {v, in_ch.point_reading};
              n_points++;
            end
          end
          default: ;
        endcase
        want.points_held = HELD_W'(n_points);
        expected_readings.push_back(want);
      end

      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.reading, out_ch.is_raw, out_ch.points_held, out_ch.point_dropped};
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result: reading %0d raw %0b held %0d dropped %0b",
                     $time, got.reading, got.is_raw, got.points_held, got.point_dropped);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected reading %0d raw %0b held %0d dropped %0b, got reading %0d raw %0b held %0d dropped %0b",
                       $time, want.reading, want.is_raw, want.points_held,
                       want.point_dropped, got.reading, got.is_raw, got.points_held,
                       got.point_dropped);
          end
        end
      end
      pending_count <= expected_readings.size();
    end
  end

endmodule

FILE: test/tb_piecewise_linear_sensor_calibration_core.sv
// testbench top: stimulus, flow control and verdict for the calibration core
module tb_piecewise_linear_sensor_calibration_core;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  localparam int RANDOM_ITEMS  = 520;
  localparam int PHASES        = 6;
  localparam int CALM_TAIL     = 60;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_sent;
  int   cycle_count;
  int   calm_from = 32'h7FFF_FFFF;
  bit   calm;

  plc_in_if  in_ch ();
  plc_out_if out_ch ();
  plc_cfg_if cfg_ch ();

  piecewise_linear_sensor_calibration_core #(
    .MAX_POINTS(DEF_MAX_POINTS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  plc_reading_checker #(
    .MAX_POINTS(DEF_MAX_POINTS)
  ) reading_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_sink
    int rx_count;
    int stall_left;
    bit held;
    rx_count   = 0;
    stall_left = 0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) rx_count++;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && rx_count >= HOLD_AT) begin
        // long hold-off so the core backs up and stalls its input
        held = 1'b1;
        out_ch.ready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [MV_W-1:0] mv,
                           input logic [RD_W-1:0] rd);
    int gap;
    calm = (items_sent >= calm_from);
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.volts_mv      <= mv;
    in_ch.point_reading <= rd;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] empty_v, input logic [CFG_DATA_W-1:0] full_v,
                           input logic [CFG_DATA_W-1:0] full_rd, input logic enable);
    write_reg(CFG_EMPTY_MV, empty_v);
    write_reg(CFG_FULL_MV, full_v);
    write_reg(CFG_FULL_READING, full_rd);
    write_reg(CFG_CAL_ENABLED, {(CFG_DATA_W-1)'($urandom), enable});
    // index past the last register must be ignored
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_CAL_ENABLED + CFG_IDX_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int              phase;
    int              rand_start;
    int              n_ins;
    int              n_conv;
    int              spread;
    int              lo;
    int              roll;
    logic [MV_W-1:0] last_mv;
    logic [MV_W-1:0] mv;
    calm       = 1'b0;
    items_sent = 0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_CONVERT;
    in_ch.volts_mv      <= '0;
    in_ch.point_reading <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_EMPTY_MV;
    cfg_ch.data         <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // raw pass-through and unused code
    send_item(OP_CONVERT, '0, '0);
    send_item(OP_CONVERT, '1, '1);
    send_item(OP_UNUSED, 13'd1234, '1);
    wait_idle();

    // legacy line with reset values, clamps at both ends
    configure(CFG_DATA_W'(RST_EMPTY_MV), CFG_DATA_W'(RST_FULL_MV),
              CFG_DATA_W'(RST_FULL_READING), 1'b1);
    send_item(OP_CONVERT, '0, '0);
    send_item(OP_CONVERT, '1, '0);
    send_item(OP_CONVERT, 13'd1751, '0);
    send_item(OP_INSERT, 13'd4000, '1);
    send_item(OP_CONVERT, 13'd4000, '0);
    wait_idle();

    // zero legacy span, then table with equal voltages and falling segment
    configure(16'd2000, 16'd2000, 16'hFFFF, 1'b1);
    send_item(OP_CONVERT, 13'd2000, '0);
    send_item(OP_INSERT, 13'd4000, 16'd100);
    send_item(OP_INSERT, 13'd0, 16'd0);
    send_item(OP_INSERT, '1, 16'd0);
    send_item(OP_CONVERT, '0, '0);
    send_item(OP_CONVERT, 13'd2001, '0);
    send_item(OP_CONVERT, 13'd4000, '0);
    send_item(OP_CONVERT, 13'd6000, '0);
    send_item(OP_CONVERT, '1, '0);

    // fill the table, overflow, clear
    repeat (12) send_item(OP_INSERT, MV_W'($urandom), RD_W'($urandom));
    send_item(OP_INSERT, 13'd100, 16'd1);
    send_item(OP_CONVERT, 13'd3333, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_CONVERT, 13'd2500, '0);

    rand_start = items_sent;
    calm_from  = rand_start + RANDOM_ITEMS - CALM_TAIL;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: configure(16'd0, 16'h1FFF, 16'hFFFF, 1'b1);
        1: configure(16'hFFFF, 16'd0, CFG_DATA_W'($urandom), 1'b1);
        2: configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0);
        3: configure(16'd0, 16'd1, 16'd0, 1'b1);
        default: configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                           CFG_DATA_W'($urandom), 1'b1);
      endcase
      while (items_sent < rand_start + (phase + 1) * RANDOM_ITEMS / PHASES) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_item(OP_W'($urandom), MV_W'($urandom), RD_W'($urandom));
        end else begin
          // skipping the clear lets the table grow until it overflows
          if (roll >= 30) send_item(OP_CLEAR, MV_W'($urandom), RD_W'($urandom));
          spread  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 64) : 8191;
          lo      = $urandom_range(0, 8191 - spread);
          n_ins   = $urandom_range(0, 18);
          last_mv = MV_W'(lo);
          repeat (n_ins) begin
            if ($urandom_range(0, 4) != 0) last_mv = MV_W'(lo + $urandom_range(0, spread));
            send_item(OP_INSERT, last_mv, RD_W'($urandom));
          end
          n_conv = $urandom_range(3, 12);
          repeat (n_conv) begin
            case ($urandom_range(0, 5))
              0:       mv = '0;
              1:       mv = '1;
              2:       mv = MV_W'($urandom);
              default: mv = MV_W'(lo + $urandom_range(0, spread));
            endcase
            send_item(OP_CONVERT, mv, RD_W'($urandom));
          end
        end
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: piecewise_linear_sensor_calibration_core.f
+incdir+sv
sv/plc_pkg.sv
sv/plc_ifs.sv
sv/plc_ram.sv
sv/plc_div.sv
sv/piecewise_linear_sensor_calibration_core.sv
sv/plc_checker.sv
test/plc_reading_checker.sv
test/tb_piecewise_linear_sensor_calibration_core.sv
